// File: sv/occupancy_grid_square_inflation_defines.svh
// assertion macros used by the occupancy grid inflation control module
`ifndef OCCUPANCY_GRID_SQUARE_INFLATION_DEFINES_SVH
`define OCCUPANCY_GRID_SQUARE_INFLATION_DEFINES_SVH

// same-cycle implication, quiet during reset
`define OGSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define OGSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ogsi_pkg.sv
// shared types and constants for the occupancy grid square inflation block
package ogsi_pkg;

  localparam int GRID_X_DEF     = 64;
  localparam int GRID_Y_DEF     = 64;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int COORD_W    = 6;
  localparam int COST_W     = 8;
  localparam int GSIZE_W    = 7;
  localparam int RAD_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [GSIZE_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [GSIZE_W-1:0] GRID_HEIGHT_RST = 7'd64;
  localparam logic [RAD_W-1:0]   RADIUS_RST      = 4'd1;
  localparam logic [COST_W-1:0]  FREE_COST_RST   = 8'd0;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_INFLATE_RADIUS,
    CFG_FREE_COST
  } cfg_idx_t;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COST_W-1:0]  cell_cost;
  } item_t;

  typedef struct packed {
    logic inflated;
    logic out_of_range;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_W_READ,
    ST_W_WRITE,
    ST_Q_RUN,
    ST_Q_TAIL,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_hit;
    logic addr_load;
    logic addr_inc;
    logic mem_rd;
    logic acc;
    logic wr_row;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_storage;
    logic oor;
    logic last_row;
    logic out_free;
  } ctl_sts_t;

endpackage

// File: sv/ogsi_datapath.sv
// occupancy row memory, window bounds, hit accumulation and result register
module ogsi_datapath
  import ogsi_pkg::*;
#(
  parameter int GRID_X     = GRID_X_DEF,
  parameter int GRID_Y     = GRID_Y_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  output result_t               result,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts
);

  localparam int XW  = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YW  = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int GXW = $clog2(GRID_X + 1);
  localparam int GYW = $clog2(GRID_Y + 1);
  localparam int RW  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int SW  = ((RW > COORD_W) ? RW : COORD_W) + 1;
  localparam int GW  = (GXW > GYW) ? GXW : GYW;
  localparam int CW0 = (GW > SW) ? GW : SW;
  localparam int CW  = (CW0 > GSIZE_W) ? CW0 + 1 : GSIZE_W + 1;

  logic [GSIZE_W-1:0] grid_width;
  logic [GSIZE_W-1:0] grid_height;
  logic [RAD_W-1:0]   inflate_radius;
  logic [COST_W-1:0]  free_cost;

  item_t              cur;
  logic [XW-1:0]      addr_cnt;
  logic [GRID_Y-1:0]  mem [GRID_X];
  logic [GRID_X-1:0]  row_valid;
  logic [GRID_Y-1:0]  rd_row;
  logic               rd_vld;
  logic               rd_live;
  logic               hit;
  logic               out_valid;
  result_t            out_data;

  logic [CW-1:0]      w_eff;
  logic [CW-1:0]      h_eff;
  logic [CW-1:0]      r_eff;
  logic [CW-1:0]      cx_w;
  logic [CW-1:0]      cy_w;
  logic [CW-1:0]      x0;
  logic [CW-1:0]      x1;
  logic [CW-1:0]      x1_raw;
  logic [CW-1:0]      y0;
  logic [CW-1:0]      y1;
  logic [CW-1:0]      y1_raw;
  logic [GRID_Y-1:0]  mask;
  logic [GRID_Y-1:0]  wr_data;
  logic               oor;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= GRID_WIDTH_RST;
      grid_height    <= GRID_HEIGHT_RST;
      inflate_radius <= RADIUS_RST;
      free_cost      <= FREE_COST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:     grid_width     <= cfg_data[GSIZE_W-1:0];
        CFG_GRID_HEIGHT:    grid_height    <= cfg_data[GSIZE_W-1:0];
        CFG_INFLATE_RADIUS: inflate_radius <= cfg_data[RAD_W-1:0];
        CFG_FREE_COST:      free_cost      <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
  end

  // window bounds, clipped to the grid size in use
  always_comb begin
    w_eff  = (CW'(grid_width) > CW'(GRID_X)) ? CW'(GRID_X) : CW'(grid_width);
    h_eff  = (CW'(grid_height) > CW'(GRID_Y)) ? CW'(GRID_Y) : CW'(grid_height);
    r_eff  = (CW'(inflate_radius) > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS)
                                                      : CW'(inflate_radius);
    cx_w   = CW'(cur.cell_x);
    cy_w   = CW'(cur.cell_y);
    oor    = (cx_w >= w_eff) || (cy_w >= h_eff);
    x0     = (cx_w >= r_eff) ? cx_w - r_eff : '0;
    y0     = (cy_w >= r_eff) ? cy_w - r_eff : '0;
    x1_raw = cx_w + r_eff;
    y1_raw = cy_w + r_eff;
    x1     = (x1_raw > w_eff - CW'(1)) ? w_eff - CW'(1) : x1_raw;
    y1     = (y1_raw > h_eff - CW'(1)) ? h_eff - CW'(1) : y1_raw;
  end

  always_comb begin
    for (int j = 0; j < GRID_Y; j++) begin
      mask[j] = (CW'(j) >= y0) && (CW'(j) <= y1);
    end
  end

  // row after a single-cell update
  always_comb begin
    wr_data = rd_vld ? rd_row : '0;
    wr_data[cy_w[YW-1:0]] = (cur.cell_cost != free_cost);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_load) begin
      addr_cnt <= (cur.action == ACT_QUERY) ? x0[XW-1:0] : cx_w[XW-1:0];
    end else if (cmd.addr_inc) begin
      addr_cnt <= addr_cnt + XW'(1);
    end
  end

  // occupancy rows, one row per first-axis index
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_row <= mem[addr_cnt];
      rd_vld <= row_valid[addr_cnt];
    end
    if (cmd.wr_row) begin
      mem[addr_cnt] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= cmd.mem_rd;
      if (cmd.wr_row) begin
        row_valid[addr_cnt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_hit) begin
      hit <= 1'b0;
    end else if (cmd.acc && rd_live && rd_vld) begin
      hit <= hit | (|(rd_row & mask));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.inflated     <= hit && !oor;
      out_data.out_of_range <= oor;
    end
  end

  assign result       = out_data;
  assign result_valid = out_valid;

  always_comb begin
    sts.is_query   = (cur.action == ACT_QUERY);
    sts.in_storage = (cx_w < CW'(GRID_X)) && (cy_w < CW'(GRID_Y));
    sts.oor        = oor;
    sts.last_row   = (CW'(addr_cnt) == x1);
    sts.out_free   = !out_valid || !result_stall;
  end

endmodule

// File: sv/ogsi_ctrl.sv
// sequencing state machine for writes and window queries
`include "occupancy_grid_square_inflation_defines.svh"

module ogsi_ctrl
  import ogsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clr_hit   = 1'b1;
        cmd.addr_load = 1'b1;
        if (!sts.is_query) begin
          state_next = sts.in_storage ? ST_W_READ : ST_IDLE;
        end else begin
          state_next = sts.oor ? ST_Q_DONE : ST_Q_RUN;
        end
      end
      ST_W_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_W_WRITE;
      end
      ST_W_WRITE: begin
        cmd.wr_row = 1'b1;
        state_next = ST_IDLE;
      end
      ST_Q_RUN: begin
        cmd.mem_rd   = 1'b1;
        cmd.acc      = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.last_row) begin
          state_next = ST_Q_TAIL;
        end
      end
      ST_Q_TAIL: begin
        cmd.acc    = 1'b1;
        state_next = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `OGSI_ASSERT_NEXT(a_accept_decode, item_valid && !item_stall, state == ST_DECODE, "request not decoded")
  `OGSI_ASSERT_NEXT(a_run_holds, state == ST_Q_RUN && !sts.last_row, state == ST_Q_RUN, "row scan cut short")
  `OGSI_ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free, "result register overwritten")
  `OGSI_ASSERT_SAME(a_write_after_read, state == ST_W_WRITE, $past(state) == ST_W_READ, "row write without read")

endmodule

// File: sv/occupancy_grid_square_inflation.sv
// Occupancy grid with square inflation. Each request either writes a cell
// (occupied when its cost differs from free_cost) or asks whether any
// occupied cell lies within inflate_radius (Chebyshev) of a cell, the window
// clipped to the configured grid size. Writes give no result; queries give
// one, with out_of_range set for a cell outside the grid size. Occupancy is
// held as one memory row per first-axis index with a reset-cleared valid bit
// per row, so the block is usable straight after reset. Requests are handled
// one at a time: a write goes through accept, decode, row read and row write;
// a query goes through accept, decode, one read per window row through the
// single memory read port (at most 2 * MAX_RADIUS + 1 rows), a tail step and
// the result load; an out-of-range query skips the row reads and the tail. A finished
// result waits in its own register, so the next request is taken while it is
// still stalled; a query that finishes while that register is still full
// waits for it to be taken.
module occupancy_grid_square_inflation
  import ogsi_pkg::*;
#(
  parameter int GRID_X     = GRID_X_DEF,
  parameter int GRID_Y     = GRID_Y_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ogsi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ogsi_datapath #(
    .GRID_X     (GRID_X),
    .GRID_Y     (GRID_Y),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
